/* rtl/dqap_pkg.sv */
// Package with shared types and constants for the dotted-quad address parser.
`timescale 1ns / 1ps

package dqap_pkg;

    // Character codes that the parser recognizes.
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Limits of the octet accumulator and the dot counter.
    localparam logic [8:0] OCTET_MAX  = 9'd255;
    localparam logic [8:0] OCTET_SAT  = 9'd256;
    localparam logic [2:0] DOTS_QUAD  = 3'd3;
    localparam logic [2:0] DOTS_SAT   = 3'd4;

    // One character request as it moves from the input register into the core.
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_char_req;

    // One parse result.
    typedef struct packed {
        logic [31:0] address;
        logic        parse_ok;
    } t_result;

endpackage

/* rtl/dqap_if.sv */
// Stream interfaces for character requests and address results.
`timescale 1ns / 1ps

interface dqap_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface dqap_addr_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        parse_ok;

    modport source (output valid, output address, output parse_ok, input ready);
    modport sink   (input valid, input address, input parse_ok, output ready);
endinterface

/* rtl/dqap_token_core.sv */
// Token state registers and the per-character update that forms the result.
`timescale 1ns / 1ps

module dqap_token_core
    import dqap_pkg::*;
#(
    parameter int MAX_CHARS = 15
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_char_req i_req,
    output logic      o_res_valid,
    output t_result   o_res
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

    logic [8:0]       r_accum,    n_accum;
    logic [23:0]      r_done,     n_done;
    logic [2:0]       r_dots,     n_dots;
    logic [CNT_W-1:0] r_count,    n_count;
    logic             r_prev_dot, n_prev_dot;
    logic             r_failed,   n_failed;

    logic        is_dot;
    logic        is_digit;
    logic        first;
    logic [11:0] acc_times_ten;
    logic [11:0] acc_sum;
    logic        final_fail;

    assign is_dot   = (i_req.char_code == CHAR_DOT);
    assign is_digit = (i_req.char_code >= CHAR_ZERO) && (i_req.char_code <= CHAR_NINE);
    assign first    = (r_count == '0);

    // Decimal step of the accumulator: accum * 10 + digit, by shifts and adds.
    assign acc_times_ten = {r_accum, 3'b000} + {2'b00, r_accum, 1'b0};
    assign acc_sum       = acc_times_ten + {4'h0, i_req.char_code - CHAR_ZERO};

    // Next token state for the character in the input register.
    always_comb begin
        n_accum    = r_accum;
        n_done     = r_done;
        n_dots     = r_dots;
        n_count    = r_count;
        n_prev_dot = r_prev_dot;
        n_failed   = r_failed;

        if (r_count >= CNT_MAX) begin
            n_failed = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
        end

        if (is_dot) begin
            if (first || r_prev_dot || (r_accum > OCTET_MAX)) begin
                n_failed = 1'b1;
            end
            if (r_dots < DOTS_QUAD) begin
                n_done = {r_done[15:0], r_accum[7:0]};
            end else begin
                n_failed = 1'b1;
            end
            if (r_dots < DOTS_SAT) begin
                n_dots = r_dots + 1'b1;
            end
            n_accum    = '0;
            n_prev_dot = 1'b1;
        end else if (is_digit) begin
            n_accum    = (acc_sum > 12'(OCTET_SAT)) ? OCTET_SAT : acc_sum[8:0];
            n_prev_dot = 1'b0;
        end else begin
            n_failed   = 1'b1;
            n_prev_dot = 1'b0;
        end
    end

    // Result of a token that ends with this character.
    assign final_fail = n_failed || (n_dots != DOTS_QUAD) || (n_accum > OCTET_MAX);

    always_comb begin
        o_res_valid    = i_step && i_req.is_last;
        o_res.parse_ok = !final_fail;
        o_res.address  = final_fail ? '0 : {n_done, n_accum[7:0]};
    end

    // State registers; the last character of a token returns them to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_req.is_last)) begin
            r_accum    <= '0;
            r_done     <= '0;
            r_dots     <= '0;
            r_count    <= '0;
            r_prev_dot <= 1'b0;
            r_failed   <= 1'b0;
        end else if (i_step) begin
            r_accum    <= n_accum;
            r_done     <= n_done;
            r_dots     <= n_dots;
            r_count    <= n_count;
            r_prev_dot <= n_prev_dot;
            r_failed   <= n_failed;
        end
    end

endmodule

/* rtl/dotted_quad_address_parser_top.sv */
// Top level of the dotted-quad address parser: input register, core, result register.
//
//   Channel   Direction  Request contents
//   i_char    in         char_code[7:0], is_last
//   o_addr    out        address[31:0], parse_ok
//
// One character is taken per cycle unless a last character waits on a stalled result;
// a result enters the result register as its last character leaves the input
// register. The token state update is a single registered step, which sets the rate
// of one character per clock. Reset (i_rst_n low, synchronous) empties both registers
// and clears the token state. A stalled result holds the result register; characters
// that end no token keep flowing, and a last character waits in the input register.
`timescale 1ns / 1ps

module dotted_quad_address_parser_top
    import dqap_pkg::*;
#(
    parameter int MAX_CHARS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqap_char_if.sink   i_char,
    dqap_addr_if.source o_addr
);

    logic      r_in_valid;
    t_char_req r_in_req;
    logic      r_out_valid;
    t_result   r_out_res;

    logic      consume;
    logic      res_valid;
    t_result   res;

    // The input register moves on unless a result is ready and the output is blocked.
    assign consume      = r_in_valid &&
                          (!r_in_req.is_last || !r_out_valid || o_addr.ready);
    assign i_char.ready = !r_in_valid || consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_req.char_code <= i_char.char_code;
            r_in_req.is_last   <= i_char.is_last;
        end
    end

    dqap_token_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (consume),
        .i_req       (r_in_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_addr.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_res <= res;
        end
    end

    assign o_addr.valid    = r_out_valid;
    assign o_addr.address  = r_out_res.address;
    assign o_addr.parse_ok = r_out_res.parse_ok;

endmodule

/* rtl/dqap_checker.sv */
// Port-level checks on the parser top level, with the bind that attaches them.
`timescale 1ns / 1ps

module dqap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_address,
    input logic        i_parse_ok
);

    // A failed parse always reports a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_parse_ok) |-> (i_address == 32'h0))
        else $error("failed parse with nonzero address");

    // With the result register empty the parser always takes a character.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result is pending");

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_address) && $stable(i_parse_ok)))
        else $error("result changed while stalled");

endmodule

bind dotted_quad_address_parser_top dqap_checker u_dqap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_addr.valid),
    .i_out_ready (o_addr.ready),
    .i_address   (o_addr.address),
    .i_parse_ok  (o_addr.parse_ok)
);

/* tb/sv/dotted_quad_address_parser_top_tb.sv */
// Self-checking testbench for the dotted-quad address parser top level.
`timescale 1ns / 1ps

module dotted_quad_address_parser_top_tb;
    import dqap_pkg::*;

    localparam int TOKEN_LIMIT  = 15;
    localparam int DECIMAL_BASE = 10;
    localparam int STALL_LEN    = 300;
    localparam int PHASE_CHARS  = 370;

    // Tracks the token state and holds the addresses still owed by the block.
    class quad_address_checker;
        logic [8:0]  digit_sum;
        logic [23:0] packed_octets;
        logic [2:0]  dots_seen;
        logic [3:0]  chars_seen;
        bit          after_dot;
        bit          token_bad;
        t_result     pending_addresses[$];
        int unsigned error_count;

        function new();
            error_count = 0;
            restart_token();
        endfunction

        function void restart_token();
            digit_sum     = '0;
            packed_octets = '0;
            dots_seen     = '0;
            chars_seen    = '0;
            after_dot     = 1'b0;
            token_bad     = 1'b0;
        endfunction

        // Advance the token state by one accepted character request.
        function void take_char(logic [7:0] code, logic last);
            bit          first;
            int unsigned next_sum;
            t_result     res;
            first = (chars_seen == 0);
            if (chars_seen >= TOKEN_LIMIT) begin
                token_bad = 1'b1;
            end else begin
                chars_seen = chars_seen + 1'b1;
            end

            if (code == CHAR_DOT) begin
                if (first || after_dot) token_bad = 1'b1;
                if (digit_sum > OCTET_MAX) token_bad = 1'b1;
                if (dots_seen < DOTS_QUAD) begin
                    packed_octets = {packed_octets[15:0], digit_sum[7:0]};
                end else begin
                    token_bad = 1'b1;
                end
                if (dots_seen < DOTS_SAT) dots_seen = dots_seen + 1'b1;
                digit_sum = '0;
                after_dot = 1'b1;
            end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
                next_sum  = digit_sum * DECIMAL_BASE + (code - CHAR_ZERO);
                digit_sum = (next_sum > OCTET_SAT) ? OCTET_SAT : next_sum[8:0];
                after_dot = 1'b0;
            end else begin
                token_bad = 1'b1;
                after_dot = 1'b0;
            end

            // The last character closes the token and owes one result.
            if (last) begin
                if (dots_seen != DOTS_QUAD || digit_sum > OCTET_MAX) token_bad = 1'b1;
                if (token_bad) begin
                    res.address  = '0;
                    res.parse_ok = 1'b0;
                end else begin
                    res.address  = {packed_octets, digit_sum[7:0]};
                    res.parse_ok = 1'b1;
                end
                pending_addresses.push_back(res);
                restart_token();
            end
        endfunction

        // Compare one accepted result request with the oldest owed address.
        function void match_result(logic [31:0] address, logic parse_ok);
            t_result exp;
            if (pending_addresses.size() == 0) begin
                $error("result with no token pending: address %h parse_ok %b",
                       address, parse_ok);
                error_count++;
            end else begin
                exp = pending_addresses.pop_front();
                if (address !== exp.address) begin
                    $error("address mismatch: expected %h, actual %h", exp.address, address);
                    error_count++;
                end
                if (parse_ok !== exp.parse_ok) begin
                    $error("parse_ok mismatch: expected %b, actual %b",
                           exp.parse_ok, parse_ok);
                    error_count++;
                end
            end
        endfunction

        function int owed();
            return pending_addresses.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dqap_char_if char_bus ();
    dqap_addr_if addr_bus ();

    dotted_quad_address_parser_top #(
        .MAX_CHARS (TOKEN_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_addr  (addr_bus)
    );

    quad_address_checker checker_h;
    logic [7:0]  token_text[$];
    int          tx_idle_pct;
    int          rx_idle_pct;
    int unsigned chars_sent;
    int unsigned hold_grants;
    int unsigned hold_seen;
    int unsigned hold_left;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Known values on every input from the start of the run.
    initial begin
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.is_last   = 1'b0;
        addr_bus.ready     = 1'b0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        chars_sent         = 0;
        hold_grants        = 0;
        hold_seen          = 0;
        hold_left          = 0;
        checker_h          = new();
    end

    // Result side: check each accepted request, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && addr_bus.valid && addr_bus.ready) begin
            checker_h.match_result(addr_bus.address, addr_bus.parse_ok);
        end
        if (hold_grants != hold_seen) begin
            hold_seen = hold_grants;
            hold_left = STALL_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            addr_bus.ready <= 1'b0;
        end else begin
            addr_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one character request, with random idle cycles ahead of it.
    task automatic send_char(input logic [7:0] code, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            char_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        char_bus.is_last   <= last;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        checker_h.take_char(code, last);
        chars_sent++;
    endtask

    task automatic send_token();
        for (int k = 0; k < token_text.size(); k++) begin
            send_char(token_text[k], k == token_text.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        token_text.delete();
        for (int k = 0; k < s.len(); k++) token_text.push_back(s[k]);
        send_token();
    endtask

    // Append an octet in decimal with the given number of leading zeros.
    function automatic void add_octet(int value, int zeros);
        string s;
        s = $sformatf("%0d", value);
        repeat (zeros) token_text.push_back(CHAR_ZERO);
        for (int k = 0; k < s.len(); k++) token_text.push_back(s[k]);
    endfunction

    function automatic int pick_octet();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Append n dot-separated octets; the final one may be left empty.
    function automatic void build_quad(int n, bit empty_tail);
        for (int i = 0; i < n; i++) begin
            if (i > 0) token_text.push_back(CHAR_DOT);
            if (!(empty_tail && i == n - 1)) begin
                add_octet(pick_octet(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            end
        end
    endfunction

    // Build one random token: mostly well formed, some broken, some noise.
    function automatic void make_token();
        int         roll;
        int         n;
        int         pos;
        int         big;
        logic [7:0] code;
        token_text.delete();
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            build_quad(4, $urandom_range(0, 11) == 0);
        end else if (roll < 90) begin
            case ($urandom_range(0, 6))
                0: begin
                    build_quad(4, 1'b0);
                    token_text.push_front(CHAR_DOT);
                end
                1: begin
                    n = $urandom_range(1, 5);
                    if (n >= 4) n++;
                    build_quad(n, $urandom_range(0, 3) == 0);
                end
                2: begin
                    build_quad(4, 1'b0);
                    token_text.insert($urandom_range(1, token_text.size() - 1), CHAR_DOT);
                end
                3: begin
                    build_quad(4, 1'b0);
                    pos = $urandom_range(0, token_text.size() - 1);
                    do begin
                        code = 8'($urandom_range(0, 255));
                    end while (code == CHAR_DOT || (code >= CHAR_ZERO && code <= CHAR_NINE));
                    token_text[pos] = code;
                end
                4: begin
                    big = $urandom_range(0, 1) ? $urandom_range(256, 999)
                                               : $urandom_range(1000, 9999999);
                    if ($urandom_range(0, 1)) begin
                        add_octet(big, 0);
                        token_text.push_back(CHAR_DOT);
                        build_quad(3, 1'b0);
                    end else begin
                        build_quad(3, 1'b0);
                        token_text.push_back(CHAR_DOT);
                        add_octet(big, 0);
                    end
                end
                5: begin
                    // Leading zeros push the length around the character limit.
                    build_quad(4, 1'b0);
                    repeat ($urandom_range(1, 12)) token_text.push_front(CHAR_ZERO);
                end
                default: begin
                    build_quad(4, 1'b0);
                    token_text.insert($urandom_range(0, token_text.size() - 1),
                                      8'($urandom_range(0, 255)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 18)) begin
                if ($urandom_range(0, 1)) begin
                    n = $urandom_range(0, 10);
                    token_text.push_back((n == 10) ? CHAR_DOT : 8'(CHAR_ZERO + n));
                end else begin
                    token_text.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
    endfunction

    // Main sequence: reset, directed tokens, three random phases, drain.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed tokens for the extremes and each failure case.
        send_text("255.255.255.255");
        send_text("0.00.0.");
        send_text(".");
        send_text("1..2");
        send_text("1.2.3.4.5");
        send_text("1.2");
        send_text("0.0.0.256");
        send_text("1.2.3.x");
        send_text("0000000000.0.0.0");

        // Sender idles rarely while the receiver idles often.
        tx_idle_pct = 13;
        rx_idle_pct = 54;
        while (chars_sent < PHASE_CHARS) begin
            make_token();
            send_token();
        end

        // Roles swapped.
        tx_idle_pct = 54;
        rx_idle_pct = 13;
        while (chars_sent < 2 * PHASE_CHARS) begin
            make_token();
            send_token();
        end

        // No idling, opened by a long receiver hold-off so the block backs up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_grants <= hold_grants + 1;
        while (chars_sent < 3 * PHASE_CHARS) begin
            make_token();
            send_token();
        end
        char_bus.valid <= 1'b0;

        while (checker_h.owed() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (checker_h.error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dqap_pkg.sv
rtl/dqap_if.sv
rtl/dqap_token_core.sv
rtl/dotted_quad_address_parser_top.sv
rtl/dqap_checker.sv
tb/sv/dotted_quad_address_parser_top_tb.sv
